/* design/bia_pkg.sv */
// Shared constants and types for the bitmap inode/block allocator.
// Used by the allocator top level and its port checker; no dependencies.
package bia_pkg;

    localparam int NUM_INODES   = 64;
    localparam int TOTAL_BLOCKS = 1024;

    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int BLK_WORDS  = TOTAL_BLOCKS / WORD_W;
    localparam int INO_WORDS  = NUM_INODES / WORD_W;
    localparam int INO_WB     = $clog2(INO_WORDS);
    localparam int MEM_WORDS  = BLK_WORDS + INO_WORDS;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int INO_BASE   = BLK_WORDS;

    localparam int IDX_W      = 10;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int INO_CNT_W  = 7;
    localparam int BLK_CNT_W  = 11;

    localparam int S_DATA_W   = 16;
    localparam int S_PAD_W    = S_DATA_W - IDX_W;
    localparam int M_FIELDS_W = IDX_W + STATUS_W + INO_CNT_W + BLK_CNT_W;
    localparam int M_DATA_W   = 32;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    localparam int FDB_RESET  = 4;

    typedef logic [OP_W-1:0]     opcode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [MEM_AW-1:0]   maddr_t;

    localparam opcode_t OP_ALLOC_INODE = 2'd0;
    localparam opcode_t OP_FREE_INODE  = 2'd1;
    localparam opcode_t OP_ALLOC_BLOCK = 2'd2;
    localparam opcode_t OP_FREE_BLOCK  = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NONE_FREE = 2'd1;
    localparam status_t ST_BAD_FREE  = 2'd2;

endpackage

/* design/bitmap_inode_block_allocator.sv */
// Bitmap allocator for inodes and data blocks, first fit.
// Depends on bia_pkg for sizes, opcodes and status codes.

// Both free maps live in one 34 x 32-bit synchronous RAM (rows 0-31 block map,
// rows 32-33 inode map) with a row-valid flop per row, so an unwritten row
// reads as all free and no clearing pass is needed after reset. One word is
// handled at a time. An in-range free goes through accept with the read,
// check and write, then output load. An allocation scans one RAM row per
// cycle, the next read overlapping the current check; the single RAM read
// port sets that scan rate. The next word is accepted in the cycle after the
// result moves to the output register, even if that result is still stalled.
module bitmap_inode_block_allocator
    import bia_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // [9:0] index, [15:10] zero
    input  logic [OP_W-1:0]     s_tuser,     // [1:0] opcode

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,     // [9:0] granted_index, [11:10] status,
                                             // [18:12] free_inodes, [29:19] free_blocks,
                                             // [31:30] zero

    input  logic                cfg_wr_en,
    input  logic [IDX_W-1:0]    cfg_wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    opcode_t              op_reg, op_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    maddr_t               base_reg, base_next;
    maddr_t               last_reg, last_next;
    maddr_t               chk_reg, chk_next;
    maddr_t               rd_ptr_reg, rd_ptr_next;
    logic                 first_reg, first_next;
    word_t                first_mask_reg, first_mask_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    status_t              res_status_reg, res_status_next;
    logic [INO_CNT_W-1:0] ino_cnt_reg, ino_cnt_next;
    logic [BLK_CNT_W-1:0] blk_cnt_reg, blk_cnt_next;
    logic [IDX_W-1:0]     fdb_reg, fdb_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [MEM_WORDS-1:0] row_valid_reg, row_valid_next;

    word_t                mem [MEM_WORDS];
    word_t                rdata_reg;
    maddr_t               rd_addr_q_reg;

    logic                 rd_en;
    maddr_t               rd_addr;
    logic                 wr_en;
    maddr_t               wr_addr;
    word_t                wr_data;

    logic                 accept;
    logic [IDX_W-1:0]     s_index;
    opcode_t              s_op;
    maddr_t               fdb_word;
    word_t                eff_word;
    word_t                scan_word;
    logic                 scan_hit;
    logic [BIT_W-1:0]     scan_pos;
    maddr_t               word_off;
    logic                 free_bit;

    function automatic maddr_t step_ptr(input maddr_t p, input maddr_t lim);
        step_ptr = (p == lim) ? p : p + maddr_t'(1);
    endfunction

    assign s_index  = s_tdata[IDX_W-1:0];
    assign s_op     = s_tuser;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fdb_word = maddr_t'(fdb_reg[IDX_W-1:BIT_W]);

    // unwritten rows read as all free
    assign eff_word  = row_valid_reg[rd_addr_q_reg] ? rdata_reg : '1;
    assign scan_word = eff_word & (first_reg ? first_mask_reg : '1);
    assign scan_hit  = |scan_word;
    assign word_off  = chk_reg - base_reg;
    assign free_bit  = eff_word[idx_reg[BIT_W-1:0]];

    always_comb
    begin
        scan_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (scan_word[i])
            begin
                scan_pos = BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        last_next       = last_reg;
        chk_next        = chk_reg;
        rd_ptr_next     = rd_ptr_reg;
        first_next      = first_reg;
        first_mask_next = first_mask_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        ino_cnt_next    = ino_cnt_reg;
        blk_cnt_next    = blk_cnt_reg;
        fdb_next        = fdb_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        row_valid_next  = row_valid_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        if (cfg_wr_en)
        begin
            fdb_next = cfg_wr_data;
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = s_op;
                    idx_next        = s_index;
                    res_idx_next    = s_index;
                    res_status_next = ST_OK;
                    first_next      = 1'b1;
                    first_mask_next = '1;
                    case (s_op)
                        OP_ALLOC_INODE:
                        begin
                            base_next   = maddr_t'(INO_BASE);
                            last_next   = maddr_t'(MEM_WORDS - 1);
                            chk_next    = maddr_t'(INO_BASE);
                            rd_ptr_next = step_ptr(maddr_t'(INO_BASE), maddr_t'(MEM_WORDS - 1));
                            rd_en       = 1'b1;
                            rd_addr     = maddr_t'(INO_BASE);
                            state_next  = S_SCAN;
                        end
                        OP_FREE_INODE:
                        begin
                            if (s_index < IDX_W'(NUM_INODES))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = maddr_t'(INO_BASE)
                                           + maddr_t'(s_index[BIT_W+INO_WB-1:BIT_W]);
                                state_next = S_FREE;
                            end
                            else
                            begin
                                res_status_next = ST_BAD_FREE;
                                state_next      = S_DONE;
                            end
                        end
                        OP_ALLOC_BLOCK:
                        begin
                            if ({1'b0, fdb_reg} >= (IDX_W + 1)'(TOTAL_BLOCKS))
                            begin
                                res_idx_next    = '0;
                                res_status_next = ST_NONE_FREE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                base_next       = '0;
                                last_next       = maddr_t'(BLK_WORDS - 1);
                                chk_next        = fdb_word;
                                rd_ptr_next     = step_ptr(fdb_word, maddr_t'(BLK_WORDS - 1));
                                first_mask_next = '1 << fdb_reg[BIT_W-1:0];
                                rd_en           = 1'b1;
                                rd_addr         = fdb_word;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if ({1'b0, s_index} < (IDX_W + 1)'(TOTAL_BLOCKS))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = maddr_t'(s_index[IDX_W-1:BIT_W]);
                                state_next = S_FREE;
                            end
                            else
                            begin
                                res_status_next = ST_BAD_FREE;
                                state_next      = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read of the next row overlaps the check of this one
                rd_en       = 1'b1;
                rd_addr     = rd_ptr_reg;
                rd_ptr_next = step_ptr(rd_ptr_reg, last_reg);
                if (scan_hit)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = chk_reg;
                    wr_data         = eff_word & ~(word_t'(1) << scan_pos);
                    res_idx_next    = {word_off[IDX_W-BIT_W-1:0], scan_pos};
                    res_status_next = ST_OK;
                    if (op_reg == OP_ALLOC_INODE)
                    begin
                        ino_cnt_next = ino_cnt_reg - INO_CNT_W'(1);
                    end
                    else
                    begin
                        blk_cnt_next = blk_cnt_reg - BLK_CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
                else if (chk_reg == last_reg)
                begin
                    res_idx_next    = '0;
                    res_status_next = ST_NONE_FREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    chk_next   = chk_reg + maddr_t'(1);
                    first_next = 1'b0;
                end
            end

            S_FREE:
            begin
                if (free_bit)
                begin
                    res_status_next = ST_BAD_FREE;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_q_reg;
                    wr_data = eff_word | (word_t'(1) << idx_reg[BIT_W-1:0]);
                    if (op_reg == OP_FREE_INODE)
                    begin
                        ino_cnt_next = ino_cnt_reg + INO_CNT_W'(1);
                    end
                    else
                    begin
                        blk_cnt_next = blk_cnt_reg + BLK_CNT_W'(1);
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {M_PAD_W'(0), blk_cnt_reg, ino_cnt_reg,
                                    res_status_reg, res_idx_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_ALLOC_INODE;
            idx_reg        <= '0;
            base_reg       <= '0;
            last_reg       <= '0;
            chk_reg        <= '0;
            rd_ptr_reg     <= '0;
            first_reg      <= 1'b0;
            first_mask_reg <= '1;
            res_idx_reg    <= '0;
            res_status_reg <= ST_OK;
            ino_cnt_reg    <= INO_CNT_W'(NUM_INODES);
            blk_cnt_reg    <= BLK_CNT_W'(TOTAL_BLOCKS);
            fdb_reg        <= IDX_W'(FDB_RESET);
            m_valid_reg    <= 1'b0;
            row_valid_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            base_reg       <= base_next;
            last_reg       <= last_next;
            chk_reg        <= chk_next;
            rd_ptr_reg     <= rd_ptr_next;
            first_reg      <= first_next;
            first_mask_reg <= first_mask_next;
            res_idx_reg    <= res_idx_next;
            res_status_reg <= res_status_next;
            ino_cnt_reg    <= ino_cnt_next;
            blk_cnt_reg    <= blk_cnt_next;
            fdb_reg        <= fdb_next;
            m_valid_reg    <= m_valid_next;
            row_valid_reg  <= row_valid_next;
        end
    end

    // map RAM and output word; a write only comes in the final scan or free step of an item,
    // just before the output load, so no later read of the same row can overlap it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg     <= mem[rd_addr];
            rd_addr_q_reg <= rd_addr;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* design/bia_checker.sv */
// Port-level checks for the bitmap inode/block allocator, bound to the top level.
// Depends on bia_pkg for field widths, limits and status codes.
module bia_checker
    import bia_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [IDX_W-1:0]     out_idx;
    status_t              out_status;
    logic [INO_CNT_W-1:0] out_inodes;
    logic [BLK_CNT_W-1:0] out_blocks;

    assign out_idx    = m_tdata[IDX_W-1:0];
    assign out_status = m_tdata[IDX_W +: STATUS_W];
    assign out_inodes = m_tdata[IDX_W + STATUS_W +: INO_CNT_W];
    assign out_blocks = m_tdata[IDX_W + STATUS_W + INO_CNT_W +: BLK_CNT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_status == ST_OK || out_status == ST_NONE_FREE
                      || out_status == ST_BAD_FREE))
        else $error("undefined status code");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status == ST_NONE_FREE |-> out_idx == '0)
        else $error("nothing-free result with nonzero index");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_inodes <= INO_CNT_W'(NUM_INODES)
                     && out_blocks <= BLK_CNT_W'(TOTAL_BLOCKS))
        else $error("free count above map size");

endmodule

bind bitmap_inode_block_allocator bia_checker u_bia_checker (.*);

/* sim/bitmap_inode_block_allocator_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for bitmap_inode_block_allocator: directed and random alloc/free
// traffic across several first-data-block settings, checked by a first-fit predictor.
// Depends on bia_pkg and the allocator RTL only.
module bitmap_inode_block_allocator_test;
    import bia_pkg::*;

    typedef struct packed {
        logic [M_PAD_W-1:0]   pad;
        logic [BLK_CNT_W-1:0] free_blocks;
        logic [INO_CNT_W-1:0] free_inodes;
        status_t              status;
        logic [IDX_W-1:0]     granted;
    } alloc_result_t;

    // Tracks both free maps and queues the result each accepted word should produce.
    class alloc_scoreboard;
        bit               inode_free [NUM_INODES];
        bit               block_free [TOTAL_BLOCKS];
        int               inodes_left;
        int               blocks_left;
        int               first_block;
        alloc_result_t    pending_results [$];
        int               errors;
        int               words_in;
        int               grants;
        int               none_free;
        int               bad_frees;

        function new();
            foreach (inode_free[i]) inode_free[i] = 1'b1;
            foreach (block_free[i]) block_free[i] = 1'b1;
            inodes_left = NUM_INODES;
            blocks_left = TOTAL_BLOCKS;
            first_block = FDB_RESET;
        endfunction

        function void set_first_block(int value);
            first_block = value;
        endfunction

        function void predict_request(opcode_t op, logic [IDX_W-1:0] idx);
            alloc_result_t r;
            int            i;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_ALLOC_INODE:
                begin
                    r.status = ST_NONE_FREE;
                    for (i = 0; i < NUM_INODES; i++)
                    begin
                        if (inode_free[i])
                        begin
                            inode_free[i] = 1'b0;
                            inodes_left--;
                            r.granted = IDX_W'(i);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                OP_FREE_INODE:
                begin
                    r.granted = idx;
                    if (idx < NUM_INODES && !inode_free[idx])
                    begin
                        inode_free[idx] = 1'b1;
                        inodes_left++;
                    end
                    else
                        r.status = ST_BAD_FREE;
                end
                OP_ALLOC_BLOCK:
                begin
                    r.status = ST_NONE_FREE;
                    for (i = first_block; i < TOTAL_BLOCKS; i++)
                    begin
                        if (block_free[i])
                        begin
                            block_free[i] = 1'b0;
                            blocks_left--;
                            r.granted = IDX_W'(i);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                default:
                begin
                    r.granted = idx;
                    if (idx < TOTAL_BLOCKS && !block_free[idx])
                    begin
                        block_free[idx] = 1'b1;
                        blocks_left++;
                    end
                    else
                        r.status = ST_BAD_FREE;
                end
            endcase
            r.free_inodes = INO_CNT_W'(inodes_left);
            r.free_blocks = BLK_CNT_W'(blocks_left);
            words_in++;
            if (r.status == ST_OK)
                grants++;
            else if (r.status == ST_NONE_FREE)
                none_free++;
            else
                bad_frees++;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(alloc_result_t got);
            alloc_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("granted_index", want.granted, got.granted);
            compare_field("status", want.status, got.status);
            compare_field("free_inodes", want.free_inodes, got.free_inodes);
            compare_field("free_blocks", want.free_blocks, got.free_blocks);
        endfunction

        // Random index currently handed out, or any index if none is.
        function int pick_used_inode();
            int start;
            int k;
            start = $urandom_range(NUM_INODES - 1);
            for (k = 0; k < NUM_INODES; k++)
                if (!inode_free[(start + k) % NUM_INODES])
                    return (start + k) % NUM_INODES;
            return $urandom_range(NUM_INODES - 1);
        endfunction

        function int pick_used_block();
            int start;
            int k;
            start = $urandom_range(TOTAL_BLOCKS - 1);
            for (k = 0; k < TOTAL_BLOCKS; k++)
                if (!block_free[(start + k) % TOTAL_BLOCKS])
                    return (start + k) % TOTAL_BLOCKS;
            return $urandom_range(TOTAL_BLOCKS - 1);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_wr_data;

    alloc_scoreboard     sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_left;
    int                  holds_done;
    int                  cfg_writes;

    bitmap_inode_block_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("timeout with %0d words outstanding", sb.pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, plus a long counted hold-off when requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tdata);
    end

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_word(opcode_t op, int idx);
        while ($urandom_range(99) < send_idle_pct)
            idle_sender(1);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{S_PAD_W{1'b0}}, idx[IDX_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        sb.predict_request(op, idx[IDX_W-1:0]);
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Only written with nothing in flight.
    task automatic write_first_block(int value);
        wait_drained();
        idle_sender(4);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[IDX_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_first_block(value);
        cfg_writes++;
    endtask

    task automatic run_segment(int count, int alloc_pct);
        int      n;
        int      idx;
        bit      on_inode;
        opcode_t op;
        for (n = 0; n < count; n++)
        begin
            on_inode = ($urandom_range(1) != 0);
            idx = 0;
            if ($urandom_range(99) < alloc_pct)
                op = on_inode ? OP_ALLOC_INODE : OP_ALLOC_BLOCK;
            else
            begin
                op = on_inode ? OP_FREE_INODE : OP_FREE_BLOCK;
                if ($urandom_range(99) < 80)
                    idx = on_inode ? sb.pick_used_inode() : sb.pick_used_block();
                else if ($urandom_range(1))
                    idx = $urandom_range(NUM_INODES - 1);
                else
                    idx = $urandom_range(1023);
            end
            send_word(op, idx);
        end
    endtask

    function automatic int pick_first_block();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 1023;
            2, 3:    return $urandom_range(1023, 960);
            default: return $urandom_range(1023);
        endcase
    endfunction

    function automatic int pick_alloc_pct();
        case ($urandom_range(3))
            0:       return 30;
            1:       return 60;
            2:       return 90;
            default: return 97;
        endcase
    endfunction

    initial
    begin
        int seg;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_ALLOC_INODE;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 13;
        recv_idle_pct = 63;
        hold_left     = 0;
        holds_done    = 0;
        cfg_writes    = 0;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // double frees, out-of-range frees, blocks below the data area
        send_word(OP_FREE_INODE, 0);
        send_word(OP_FREE_INODE, 63);
        send_word(OP_FREE_INODE, 64);
        send_word(OP_FREE_INODE, 1023);
        send_word(OP_FREE_BLOCK, 1023);
        send_word(OP_FREE_BLOCK, 0);
        send_word(OP_ALLOC_INODE, 1023);
        send_word(OP_ALLOC_BLOCK, 0);
        send_word(OP_FREE_INODE, 0);
        send_word(OP_FREE_BLOCK, 4);
        send_word(OP_ALLOC_BLOCK, 0);
        // small data area runs dry
        write_first_block(1021);
        repeat (4) send_word(OP_ALLOC_BLOCK, 0);
        send_word(OP_FREE_BLOCK, 1023);
        send_word(OP_ALLOC_BLOCK, 0);
        write_first_block(1023);
        send_word(OP_ALLOC_BLOCK, 0);
        send_word(OP_FREE_BLOCK, 1023);
        send_word(OP_ALLOC_BLOCK, 0);
        write_first_block(0);
        send_word(OP_ALLOC_BLOCK, 0);
        send_word(OP_ALLOC_INODE, 0);

        for (seg = 0; seg < 15; seg++)
        begin
            write_first_block(pick_first_block());
            if (seg < 5)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 63;
            end
            else if (seg < 10)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long output stall while input keeps coming, so s_tready must drop
            if (seg == 2 || seg == 12)
            begin
                hold_left = 300;
                holds_done++;
            end
            run_segment(102, pick_alloc_pct());
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Sent %0d words over %0d first-block settings and %0d long output stalls.",
                 sb.words_in, cfg_writes, holds_done);
        $display("Results: %0d granted or freed, %0d nothing free, %0d bad frees.",
                 sb.grants, sb.none_free, sb.bad_frees);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
design/bia_pkg.sv
design/bitmap_inode_block_allocator.sv
design/bia_checker.sv
sim/bitmap_inode_block_allocator_test.sv
